FILE: rtl/drd_pkg.sv
// Shared types and constants for the XOR-delta run-length frame decoder.
// Used by every module of the decoder; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package drd_pkg;

  localparam logic [15:0] FRAME_SIZE_RESET = 16'd64000;
  localparam logic [7:0]  EXT_MARK         = 8'd255;
  localparam int          QUEUE_DEPTH_DEF  = 2;

  // Parser phases, one-hot.
  typedef enum logic [8:0] {
    PH_EQ_COUNT  = 9'b000000001,
    PH_EQ_LO     = 9'b000000010,
    PH_EQ_HI     = 9'b000000100,
    PH_EQ_COLOR  = 9'b000001000,
    PH_RAW_COUNT = 9'b000010000,
    PH_RAW_LO    = 9'b000100000,
    PH_RAW_HI    = 9'b001000000,
    PH_RAW_DATA  = 9'b010000000,
    PH_DONE      = 9'b100000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FILL = 2'd0,
    KIND_SKIP = 2'd1,
    KIND_RAW  = 2'd2
  } run_kind_t;

  // Command as it travels from the parser to the output stage.
  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] length;
    logic        is_raw;
    logic [7:0]  value;
    logic        done;
    logic        over;
  } run_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/drd_if.sv
// Channel interfaces of the decoder: compressed byte input and run command output.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

interface drd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       frame_start;

  modport source (output valid, output stream_byte, output frame_start, input ready);
  modport sink   (input valid, input stream_byte, input frame_start, output ready);
endinterface

interface drd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] run_offset;
  logic [15:0] run_length;
  logic [1:0]  run_kind;
  logic [7:0]  xor_value;
  logic        frame_done;
  logic        overrun;

  modport source (output valid, output run_offset, output run_length, output run_kind,
                  output xor_value, output frame_done, output overrun, input ready);
  modport sink   (input valid, input run_offset, input run_length, input run_kind,
                  input xor_value, input frame_done, input overrun, output ready);
endinterface

`default_nettype wire

FILE: rtl/xor_delta_rle_frame_decoder.sv
// Top level of the XOR-delta run-length frame decoder: frame size register,
// parser, command queue and output stage. Depends on drd_pkg, drd_if and submodules.
//
//   channel  | dir | handshake         | payload
//   in_ch    | in  | valid / ready     | stream_byte, frame_start
//   out_ch   | out | valid / ready     | run_offset, run_length, run_kind,
//            |     |                   | xor_value, frame_done, overrun
//   cfg      | in  | cfg_we            | cfg_wdata (frame size)
//
// One input beat is accepted every cycle while the queue has room; the parser
// updates its phase and position in that same cycle.
// A command reaches out_ch through the queue write and then the result register.
// A stalled sink fills the queue, and in_ch.ready drops only when it is full.
// Reset is synchronous; frame size returns to 64000 and the parser to an equal-run count.
`timescale 1ns / 1ps
`default_nettype none

module xor_delta_rle_frame_decoder #(
  parameter int QUEUE_DEPTH = drd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  drd_in_if.sink           in_ch,
  drd_out_if.source        out_ch
);
  import drd_pkg::*;

  logic [15:0] frame_size_r;
  logic        push_valid;
  run_cmd_t    push_cmd;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  run_cmd_t    q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= FRAME_SIZE_RESET;
    end else if (cfg_we) begin
      frame_size_r <= cfg_wdata;
    end
  end

  drd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_size (frame_size_r),
    .in_ch      (in_ch),
    .push_ready (!q_full),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  drd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .pop_cmd    (q_cmd)
  );

  drd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/drd_front.sv
// Stream parser: accepts one compressed byte per beat, tracks phase and position,
// and pushes clamped run commands into the queue. Depends on drd_pkg and drd_if.
`timescale 1ns / 1ps
`default_nettype none

module drd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [15:0]      frame_size,
  drd_in_if.sink                in_ch,
  input  wire logic             push_ready,
  output logic                  push_valid,
  output drd_pkg::run_cmd_t     push_cmd
);
  import drd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [16:0] pend_r, pend_nxt;
  logic [7:0]  ext_r, ext_nxt;

  phase_t      ph;
  logic [15:0] pos;
  logic [16:0] pend;
  logic [7:0]  ext;
  logic [15:0] remaining;
  logic [7:0]  b;
  logic        accept;
  logic        emit;
  logic        over;
  logic        done;
  logic [15:0] len;
  logic [16:0] pend_dec;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign b           = in_ch.stream_byte;

  always_comb begin
    ph   = phase_r;
    pos  = pos_r;
    pend = pend_r;
    ext  = ext_r;
    if (in_ch.frame_start) begin
      ph   = PH_EQ_COUNT;
      pos  = '0;
      pend = '0;
      ext  = '0;
    end
    // A shrunken frame size can leave the position already at the end.
    if (ph != PH_DONE && pos >= frame_size) begin
      ph = PH_DONE;
    end
    remaining = (frame_size > pos) ? (frame_size - pos) : '0;
    pend_dec  = pend - 17'd1;

    phase_nxt = ph;
    pos_nxt   = pos;
    pend_nxt  = pend;
    ext_nxt   = ext;
    emit      = 1'b0;
    over      = 1'b0;
    done      = 1'b0;
    len       = 16'd1;

    unique case (ph)
      PH_EQ_COUNT: begin
        pend_nxt  = {9'd0, b};
        phase_nxt = (b == EXT_MARK) ? PH_EQ_LO : PH_EQ_COLOR;
      end
      PH_RAW_COUNT: begin
        pend_nxt = {9'd0, b};
        if (b == EXT_MARK) begin
          phase_nxt = PH_RAW_LO;
        end else if (b == 8'd0) begin
          phase_nxt = PH_EQ_COUNT;
        end else begin
          phase_nxt = PH_RAW_DATA;
        end
      end
      PH_EQ_LO: begin
        ext_nxt   = b;
        phase_nxt = PH_EQ_HI;
      end
      PH_RAW_LO: begin
        ext_nxt   = b;
        phase_nxt = PH_RAW_HI;
      end
      PH_EQ_HI: begin
        pend_nxt  = {9'd0, EXT_MARK} + {1'b0, b, ext};
        phase_nxt = PH_EQ_COLOR;
      end
      PH_RAW_HI: begin
        pend_nxt  = {9'd0, EXT_MARK} + {1'b0, b, ext};
        phase_nxt = PH_RAW_DATA;
      end
      PH_EQ_COLOR: begin
        phase_nxt = PH_RAW_COUNT;
        if (pend != 17'd0) begin
          over     = pend > {1'b0, remaining};
          len      = over ? remaining : pend[15:0];
          done     = (len == remaining);
          emit     = 1'b1;
          pos_nxt  = pos + len;
          pend_nxt = '0;
          if (done) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_RAW_DATA: begin
        pend_nxt = pend_dec;
        done     = (remaining == 16'd1);
        over     = done && (pend_dec != 17'd0);
        emit     = 1'b1;
        pos_nxt  = pos + 16'd1;
        if (done) begin
          phase_nxt = PH_DONE;
        end else if (pend_dec == 17'd0) begin
          phase_nxt = PH_EQ_COUNT;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_EQ_COUNT;
      end
    endcase
  end

  assign push_valid      = accept && emit;
  assign push_cmd.offset = pos;
  assign push_cmd.length = len;
  assign push_cmd.is_raw = (ph == PH_RAW_DATA);
  assign push_cmd.value  = b;
  assign push_cmd.done   = done;
  assign push_cmd.over   = over;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_EQ_COUNT;
      pos_r   <= '0;
      pend_r  <= '0;
      ext_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      pend_r  <= pend_nxt;
      ext_r   <= ext_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/drd_queue.sv
// Short command queue between the parser and the output stage.
// Depends on drd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drd_queue #(
  parameter int DEPTH = drd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  input  wire drd_pkg::run_cmd_t push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output logic                   empty,
  output drd_pkg::run_cmd_t      pop_cmd
);
  import drd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  run_cmd_t      mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == FULL_COUNT);
  assign empty   = (count_r == '0);
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/drd_back.sv
// Output stage: takes commands from the queue, derives the run kind and holds
// the result register toward the sink. Depends on drd_pkg and drd_if.
`timescale 1ns / 1ps
`default_nettype none

module drd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire drd_pkg::run_cmd_t q_cmd,
  output logic                   q_pop,
  drd_out_if.source              out_ch
);
  import drd_pkg::*;

  logic        valid_r, valid_nxt;
  logic [15:0] offset_r;
  logic [15:0] length_r;
  run_kind_t   kind_r, kind_nxt;
  logic [7:0]  value_r;
  logic        done_r;
  logic        over_r;
  logic        load;

  assign load  = !q_empty && (!valid_r || out_ch.ready);
  assign q_pop = load;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    // An equal run with a zero color leaves its pixels alone.
    if (q_cmd.is_raw) begin
      kind_nxt = KIND_RAW;
    end else if (q_cmd.value != 8'd0) begin
      kind_nxt = KIND_FILL;
    end else begin
      kind_nxt = KIND_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      offset_r <= q_cmd.offset;
      length_r <= q_cmd.length;
      kind_r   <= kind_nxt;
      value_r  <= q_cmd.value;
      done_r   <= q_cmd.done;
      over_r   <= q_cmd.over;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.run_offset = offset_r;
  assign out_ch.run_length = length_r;
  assign out_ch.run_kind   = kind_r;
  assign out_ch.xor_value  = value_r;
  assign out_ch.frame_done = done_r;
  assign out_ch.overrun    = over_r;

endmodule

`default_nettype wire

FILE: rtl/drd_checker.sv
// Port-level checks on the decoder's result channel, and the bind that
// attaches them to the top level. Depends on drd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_run_length,
  input wire logic [1:0]  out_run_kind,
  input wire logic [7:0]  out_xor_value,
  input wire logic        out_frame_done,
  input wire logic        out_overrun
);
  import drd_pkg::*;

  // A beat waiting on the sink keeps its length, kind and xor value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_run_length)
      && $stable(out_xor_value) && $stable(out_run_kind))
    else $error("result beat changed while stalled");

  // A clamped run always ends the frame.
  a_over_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overrun |-> out_frame_done)
    else $error("overrun without frame_done");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length != 16'd0
      && (out_run_kind != KIND_RAW || out_run_length == 16'd1))
    else $error("bad run length");

  a_kind_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_kind == KIND_SKIP && out_xor_value == 8'd0)
      || (out_run_kind == KIND_FILL && out_xor_value != 8'd0)
      || (out_run_kind == KIND_RAW))
    else $error("run kind and xor value disagree");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind xor_delta_rle_frame_decoder drd_checker u_drd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_run_length (out_ch.run_length),
  .out_run_kind   (out_ch.run_kind),
  .out_xor_value  (out_ch.xor_value),
  .out_frame_done (out_ch.frame_done),
  .out_overrun    (out_ch.overrun)
);

`default_nettype wire
